>>> design/scq_pkg.sv
// Package for the simplex collapse quadrature map: number format, payload
// structs, single-point constants and the Jacobian numerator helpers.
// No dependencies.
package scq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FW = FRAC_BITS + 1;   // field width, Q1.FRAC_BITS
  localparam int NW = FRAC_BITS + 3;   // Jacobian numerator width (scale ONE)
  localparam int HW = FRAC_BITS + 2;   // half numerator width inside the divider

  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;
  localparam logic [FW:0] TWO_ONE = (FW + 1)'(1) << (FRAC_BITS + 1);
  localparam logic [NW-1:0] SIX_ONE = NW'(6) << FRAC_BITS;

  localparam logic [FW-1:0] ONE_THIRD = FW'(ONE / 3);
  localparam logic [FW-1:0] ONE_HALF = FW'(ONE / 2);
  localparam logic [FW-1:0] ONE_QUARTER = FW'(ONE / 4);
  localparam logic [FW-1:0] ONE_SIXTH = FW'(ONE / 6);

  localparam logic MODE_TRI = 1'b0;
  localparam logic MODE_TET = 1'b1;

  typedef struct packed {
    logic shape_mode;
    logic single_point;
    logic [FW-1:0] cube_x;
    logic [FW-1:0] cube_y;
    logic [FW-1:0] cube_z;
    logic [FW-1:0] cube_weight;
  } scq_in_t;

  typedef struct packed {
    logic [FW-1:0] node_x;
    logic [FW-1:0] node_y;
    logic [FW-1:0] node_z;
    logic [FW-1:0] node_weight;
  } scq_out_t;

  // per-item values that ride along the pipeline
  typedef struct packed {
    logic tet;
    logic single;
    logic [FW-1:0] x;
    logic [FW-1:0] y;
    logic [FW-1:0] z;
    logic [FW-1:0] w;
    logic [FW-1:0] tri_x;
    logic [FW-1:0] tri_y;
    logic [FW-1:0] tri_w;
  } scq_ctx_t;

  function automatic logic [FW-1:0] clamp_one(logic [FW-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

  // (6*ONE^2 - 3(a+b)ONE + 2ab) / ONE, exact floor; always positive
  function automatic logic [NW-1:0] diag_num(logic [FW-1:0] a, logic [FW-1:0] b,
                                             logic [2*FW-1:0] p);
    logic [NW-1:0] hi;
    hi = NW'(p >> (FRAC_BITS - 1));
    return SIX_ONE + hi - NW'(3) * (NW'(a) + NW'(b));
  endfunction

  // magnitude of (2st - 3s*ONE) / ONE, floored; the entry itself is <= 0
  function automatic logic [NW-1:0] off_num(logic [FW-1:0] s, logic [2*FW-1:0] p);
    logic [NW-1:0] hi;
    hi = NW'(p >> (FRAC_BITS - 1)) + NW'(|p[FRAC_BITS-2:0]);
    return NW'(3) * NW'(s) - hi;
  endfunction

endpackage

>>> design/simplex_collapse_quadrature_map.sv
// Top level of the simplex collapse quadrature map.
// Depends on scq_pkg and scq_div6.
//
// Maps one Q1.16 quadrature point of the unit square (triangle mode) or cube
// (tetrahedron mode) per cycle onto the simplex. The datapath is a seven-stage
// pipeline: input products, a two-stage divide by six for the nine Jacobian
// entries, two stages of triple products, the determinant sum and the weight
// scaling. A new item is accepted every cycle unless the pipe holds: the whole
// pipe holds while an output item is stalled.
module simplex_collapse_quadrature_map import scq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  scq_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output scq_out_t out_data
);

  logic en;
  logic [7:1] vld_r;

  assign en = !(vld_r[7] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], in_valid};
    end
  end

  // ---- stage 1: clamp, coordinate products, triangle map
  logic [FW-1:0] cx, cy, cz, cw;
  logic [2*FW:0] tri_xp, tri_yp, tri_wp;
  scq_ctx_t ctx1_nxt;

  assign cx = clamp_one(in_data.cube_x);
  assign cy = clamp_one(in_data.cube_y);
  assign cz = clamp_one(in_data.cube_z);
  assign cw = clamp_one(in_data.cube_weight);

  assign tri_xp = (2*FW+1)'(cx) * (2*FW+1)'(TWO_ONE - {1'b0, cy});
  assign tri_yp = (2*FW+1)'(cy) * (2*FW+1)'(TWO_ONE - {1'b0, cx});
  assign tri_wp = (2*FW+1)'(cw) * (2*FW+1)'(TWO_ONE - {1'b0, cx} - {1'b0, cy});

  always_comb begin
    ctx1_nxt.tet    = in_data.shape_mode;
    ctx1_nxt.single = in_data.single_point;
    ctx1_nxt.x      = cx;
    ctx1_nxt.y      = cy;
    ctx1_nxt.z      = cz;
    ctx1_nxt.w      = cw;
    ctx1_nxt.tri_x  = tri_xp[FRAC_BITS+1 +: FW];
    ctx1_nxt.tri_y  = tri_yp[FRAC_BITS+1 +: FW];
    ctx1_nxt.tri_w  = tri_wp[FRAC_BITS+1 +: FW];
  end

  scq_ctx_t ctx_r [1:6];
  logic [2*FW-1:0] pxy_r, pxz_r, pyz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[1] <= ctx1_nxt;
      pxy_r <= (2*FW)'(cx) * (2*FW)'(cy);
      pxz_r <= (2*FW)'(cx) * (2*FW)'(cz);
      pyz_r <= (2*FW)'(cy) * (2*FW)'(cz);
      for (int i = 2; i <= 6; i++) begin
        ctx_r[i] <= ctx_r[i-1];
      end
    end
  end

  // ---- stages 2-3: Jacobian entries, divided by six
  // order: j11 j22 j33 |j12| |j13| |j21| |j23| |j31| |j32|
  logic [NW-1:0] jnum [9];
  logic [FW-1:0] jac [9];

  assign jnum[0] = diag_num(ctx_r[1].y, ctx_r[1].z, pyz_r);
  assign jnum[1] = diag_num(ctx_r[1].x, ctx_r[1].z, pxz_r);
  assign jnum[2] = diag_num(ctx_r[1].x, ctx_r[1].y, pxy_r);
  assign jnum[3] = off_num(ctx_r[1].x, pxz_r);
  assign jnum[4] = off_num(ctx_r[1].x, pxy_r);
  assign jnum[5] = off_num(ctx_r[1].y, pyz_r);
  assign jnum[6] = off_num(ctx_r[1].y, pxy_r);
  assign jnum[7] = off_num(ctx_r[1].z, pyz_r);
  assign jnum[8] = off_num(ctx_r[1].z, pxz_r);

  for (genvar g = 0; g < 9; g++) begin : g_div
    scq_div6 u_div (
      .clk (clk),
      .en  (en),
      .num (jnum[g]),
      .quo (jac[g])
    );
  end

  // ---- stage 4: first product of each determinant term, coordinates
  // terms as (a, b, c) of ((a*b)/ONE*c)/ONE, magnitudes only
  logic [FW-1:0] ta [6], tb [6], tc [6];
  logic [FW-1:0] ab_r [6];
  logic [FW-1:0] c4_r [6];
  logic [FW-1:0] crd4_r [3];
  logic [2*FW-1:0] ab_p [6];
  logic [2*FW-1:0] crd_p [3];

  always_comb begin
    ta[0] = jac[0]; tb[0] = jac[1]; tc[0] = jac[2];
    ta[1] = jac[3]; tb[1] = jac[6]; tc[1] = jac[7];
    ta[2] = jac[4]; tb[2] = jac[5]; tc[2] = jac[8];
    ta[3] = jac[4]; tb[3] = jac[1]; tc[3] = jac[7];
    ta[4] = jac[0]; tb[4] = jac[6]; tc[4] = jac[8];
    ta[5] = jac[3]; tb[5] = jac[5]; tc[5] = jac[2];
    for (int i = 0; i < 6; i++) begin
      ab_p[i] = (2*FW)'(ta[i]) * (2*FW)'(tb[i]);
    end
    crd_p[0] = (2*FW)'(ctx_r[3].x) * (2*FW)'(jac[0]);
    crd_p[1] = (2*FW)'(ctx_r[3].y) * (2*FW)'(jac[1]);
    crd_p[2] = (2*FW)'(ctx_r[3].z) * (2*FW)'(jac[2]);
  end

  // ---- stage 5: second product
  logic [FW-1:0] m5_r [6];
  logic [FW-1:0] crd5_r [3];
  logic [2*FW-1:0] abc_p [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      abc_p[i] = (2*FW)'(ab_r[i]) * (2*FW)'(c4_r[i]);
    end
  end

  // ---- stage 6: determinant; only the first term is positive
  localparam int DW = FRAC_BITS + 4;
  logic signed [DW-1:0] det;
  logic [DW-2:0] mag_r;
  logic [FW-1:0] crd6_r [3];

  assign det = signed'(DW'(m5_r[0])) - signed'(DW'(m5_r[1])) - signed'(DW'(m5_r[2]))
             - signed'(DW'(m5_r[3])) - signed'(DW'(m5_r[4])) - signed'(DW'(m5_r[5]));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        ab_r[i] <= ab_p[i][FRAC_BITS +: FW];
        c4_r[i] <= tc[i];
        m5_r[i] <= abc_p[i][FRAC_BITS +: FW];
      end
      for (int k = 0; k < 3; k++) begin
        crd4_r[k] <= crd_p[k][FRAC_BITS +: FW];
        crd5_r[k] <= crd4_r[k];
        crd6_r[k] <= crd5_r[k];
      end
      mag_r <= det[DW-1] ? (DW-1)'(-det) : (DW-1)'(det);
    end
  end

  // ---- stage 7: weight scaling, select, output register
  logic [FW+DW-2:0] wp;
  logic [FW+DW-2:0] wsh;
  scq_out_t out_nxt;
  scq_out_t out_r;

  assign wp = (FW+DW-1)'(ctx_r[6].w) * (FW+DW-1)'(mag_r);
  assign wsh = wp >> FRAC_BITS;

  always_comb begin
    if (ctx_r[6].single) begin
      if (ctx_r[6].tet == MODE_TET) begin
        out_nxt.node_x = ONE_QUARTER;
        out_nxt.node_y = ONE_QUARTER;
        out_nxt.node_z = ONE_QUARTER;
        out_nxt.node_weight = ONE_SIXTH;
      end else begin
        out_nxt.node_x = ONE_THIRD;
        out_nxt.node_y = ONE_THIRD;
        out_nxt.node_z = '0;
        out_nxt.node_weight = ONE_HALF;
      end
    end else if (ctx_r[6].tet == MODE_TRI) begin
      out_nxt.node_x = clamp_one(ctx_r[6].tri_x);
      out_nxt.node_y = clamp_one(ctx_r[6].tri_y);
      out_nxt.node_z = '0;
      out_nxt.node_weight = clamp_one(ctx_r[6].tri_w);
    end else begin
      out_nxt.node_x = clamp_one(crd6_r[0]);
      out_nxt.node_y = clamp_one(crd6_r[1]);
      out_nxt.node_z = clamp_one(crd6_r[2]);
      out_nxt.node_weight = (wsh > (FW+DW-1)'(ONE)) ? ONE : wsh[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[7];
  assign out_data = out_r;

  // ---- checks
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.node_x <= ONE) && (out_data.node_y <= ONE)
               && (out_data.node_z <= ONE) && (out_data.node_weight <= ONE))
    else $error("result field above one");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[6] |=> out_valid)
    else $error("item lost in last pipeline stage");

endmodule

>>> design/scq_div6.sv
// Two-stage divide by six for one Jacobian entry: reciprocal multiply,
// then a single compare-and-correct. Depends on scq_pkg.
module scq_div6 import scq_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  output logic [FW-1:0] quo
);

  localparam logic [HW-1:0] RECIP = HW'(((HW + 1)'(1) << HW) / 3);

  logic [HW-1:0]   half;
  logic [2*HW-1:0] prod;
  logic [HW-1:0]   half_r;
  logic [FW-1:0]   est_r;
  logic [HW-1:0]   rem;
  logic [FW-1:0]   quo_nxt;
  logic [FW-1:0]   quo_r;

  // floor(n/6) = floor(floor(n/2)/3)
  assign half = num[NW-1:1];
  assign prod = (2*HW)'(half) * (2*HW)'(RECIP);

  // estimate is exact or one low
  assign rem = half_r - HW'(3) * HW'(est_r);
  assign quo_nxt = est_r + FW'(rem >= HW'(3));

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= half;
      est_r  <= prod[HW +: FW];
      quo_r  <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

>>> test/simplex_collapse_quadrature_map_test.sv
// Testbench for simplex_collapse_quadrature_map: random and directed quadrature
// points, each result checked against an in-bench collapse predictor.
// Depends on scq_pkg and the design under test.
`timescale 1ns / 100ps

module simplex_collapse_quadrature_map_test;
  import scq_pkg::*;

  localparam int N_RANDOM = 2000;
  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  scq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scq_out_t out_data;

  scq_in_t pending_points[$];
  scq_out_t expected_nodes[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  bit hold_long = 1'b0;

  simplex_collapse_quadrature_map dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic longint lim_in(logic [FW-1:0] v);
    return (v > ONE) ? ONE_L : longint'(v);
  endfunction

  function automatic logic [FW-1:0] sat(longint v);
    return (v > ONE_L) ? ONE : FW'(v);
  endfunction

  // SystemVerilog division truncates toward zero, matching the fixed-point spec
  function automatic longint jac_diag(longint a, longint b);
    longint num;
    num = 6 * ONE_L * ONE_L - 3 * (a + b) * ONE_L + 2 * a * b;
    return num / (6 * ONE_L);
  endfunction

  function automatic longint jac_off(longint s, longint t);
    longint num;
    num = 2 * s * t - 3 * s * ONE_L;
    return num / (6 * ONE_L);
  endfunction

  function automatic longint triple(longint a, longint b, longint c);
    longint ab;
    ab = (a * b) / ONE_L;
    return (ab * c) / ONE_L;
  endfunction

  function automatic scq_out_t collapse_point(scq_in_t p);
    scq_out_t r;
    longint x, y, z, w, j11, j22, j33, j12, j13, j21, j23, j31, j32, det;
    x = lim_in(p.cube_x);
    y = lim_in(p.cube_y);
    z = lim_in(p.cube_z);
    w = lim_in(p.cube_weight);
    if (p.single_point) begin
      if (p.shape_mode == MODE_TET) begin
        r = '{ONE_QUARTER, ONE_QUARTER, ONE_QUARTER, ONE_SIXTH};
      end else begin
        r = '{ONE_THIRD, ONE_THIRD, '0, ONE_HALF};
      end
    end else if (p.shape_mode == MODE_TRI) begin
      r.node_x = sat((x * (2 * ONE_L - y)) >>> (FRAC_BITS + 1));
      r.node_y = sat((y * (2 * ONE_L - x)) >>> (FRAC_BITS + 1));
      r.node_z = '0;
      r.node_weight = sat((w * (2 * ONE_L - x - y)) >>> (FRAC_BITS + 1));
    end else begin
      j11 = jac_diag(y, z);
      j22 = jac_diag(x, z);
      j33 = jac_diag(x, y);
      j12 = jac_off(x, z);
      j13 = jac_off(x, y);
      j21 = jac_off(y, z);
      j23 = jac_off(y, x);
      j31 = jac_off(z, y);
      j32 = jac_off(z, x);
      det = triple(j11, j22, j33) + triple(j12, j23, j31) + triple(j13, j21, j32)
          - triple(j13, j22, j31) - triple(j11, j23, j32) - triple(j12, j21, j33);
      if (det < 0) det = -det;
      r.node_x = sat((x * j11) >>> FRAC_BITS);
      r.node_y = sat((y * j22) >>> FRAC_BITS);
      r.node_z = sat((z * j33) >>> FRAC_BITS);
      r.node_weight = sat((w * det) >>> FRAC_BITS);
    end
    return r;
  endfunction

  // full 17-bit coordinate, with a bias toward the legal range and the edges
  function automatic logic [FW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return FW'($urandom);
      1: return ONE;
      2: return '0;
      3: return ONE - FW'($urandom_range(0, 3));
      default: return FW'($urandom_range(0, 1 << FRAC_BITS));
    endcase
  endfunction

  function automatic scq_in_t make_point(bit mode, bit single, logic [FW-1:0] x,
                                         logic [FW-1:0] y, logic [FW-1:0] z,
                                         logic [FW-1:0] w);
    scq_in_t p;
    p.shape_mode = mode;
    p.single_point = single;
    p.cube_x = x;
    p.cube_y = y;
    p.cube_z = z;
    p.cube_weight = w;
    return p;
  endfunction

  // driver: a random gap, possibly none, after each accepted item
  int send_gap = 0;
  int gap_draw = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_nodes.push_back(collapse_point(in_data));
        n_sent++;
        gap_draw = $urandom_range(0, 10);
        if (pending_points.size() > 0 && gap_draw == 0) begin
          in_data <= pending_points.pop_front();
        end else begin
          in_valid <= 1'b0;
          send_gap = (gap_draw > 0) ? gap_draw - 1 : 0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_points.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_points.pop_front();
        end
      end
    end
  end

  // monitor and stall control; one long hold-off partway into the run
  int stall_left = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_nodes.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_data);
          errors++;
        end else begin
          scq_out_t e;
          e = expected_nodes.pop_front();
          if (e.node_x !== out_data.node_x)
            $display("%0t: node_x expected %h actual %h", $time, e.node_x, out_data.node_x);
          if (e.node_y !== out_data.node_y)
            $display("%0t: node_y expected %h actual %h", $time, e.node_y, out_data.node_y);
          if (e.node_z !== out_data.node_z)
            $display("%0t: node_z expected %h actual %h", $time, e.node_z, out_data.node_z);
          if (e.node_weight !== out_data.node_weight)
            $display("%0t: node_weight expected %h actual %h", $time, e.node_weight,
                     out_data.node_weight);
          if (e !== out_data) errors++;
          n_checked++;
        end
      end
      if (!hold_long && n_sent >= 600) begin
        hold_long = 1'b1;
        hold_cnt = 80;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (n_sent > 1200 && n_sent < 1500) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  initial begin
    for (int m = 0; m < 2; m++) begin
      pending_points.push_back(make_point(1'(m), 1'b0, '0, '0, '0, '0));
      pending_points.push_back(make_point(1'(m), 1'b0, ONE, ONE, ONE, ONE));
      pending_points.push_back(make_point(1'(m), 1'b0, '1, '1, '1, '1));
      pending_points.push_back(make_point(1'(m), 1'b0, ONE, '0, '0, ONE));
      pending_points.push_back(make_point(1'(m), 1'b0, '0, ONE, '0, ONE));
      pending_points.push_back(make_point(1'(m), 1'b0, '0, '0, ONE, ONE));
      pending_points.push_back(make_point(1'(m), 1'b0, ONE_HALF, ONE_HALF, ONE_HALF, ONE));
      pending_points.push_back(make_point(1'(m), 1'b0, ONE + FW'(1), ONE_THIRD, '1,
                                          ONE + FW'(5)));
      pending_points.push_back(make_point(1'(m), 1'b1, '1, '0, ONE, '1));
      pending_points.push_back(make_point(1'(m), 1'b1, '0, '0, '0, '0));
      pending_points.push_back(make_point(1'(m), 1'b0, 17'h0AAAA, 17'h15555, 17'h05555,
                                          ONE_HALF));
    end
    for (int i = 0; i < N_RANDOM; i++)
      pending_points.push_back(make_point(1'($urandom_range(0, 1)),
                                          ($urandom_range(0, 7) == 0),
                                          rand_coord(), rand_coord(), rand_coord(),
                                          rand_coord()));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_points.size() == 0 && !in_valid);
    wait (expected_nodes.size() == 0);
    repeat (20) @(posedge clk);
    $display("covered %0d points in triangle and tetrahedron modes, %0d results checked",
             n_sent, n_checked);
    if (errors == 0 && expected_nodes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

endmodule
